/* hdl/idt_pkg.sv */
`default_nettype none

package idt_pkg;

	localparam int SLOT_COUNT_DEF = 16;
	localparam int MAX_RESULTS = 16;
	localparam int KEY_W = 32;
	localparam int SLOT_W = 4;
	localparam int CNT_W = $clog2(MAX_RESULTS + 1);

	typedef enum logic [2:0] {
		MODE_INSERT = 3'd0,
		MODE_LOOKUP = 3'd1,
		MODE_UPDATE = 3'd2,
		MODE_DELETE = 3'd3,
		MODE_LIST   = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_CMP,
		S_LPUSH,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic             en;
		logic [KEY_W-1:0] data;
	} wr_req_t;

endpackage

`default_nettype wire

/* hdl/id_table_first_free_insert_core.sv */
// Each operation scans the table through one registered read port, with a read state and a compare state per slot.
// Insert, lookup, update, delete: the scan stops at the first hit or at the last slot (SLOT_COUNT-1).
// List: one result per occupied slot, at most MAX_RESULTS, until the scan ends; one item at a time.
// A new item is taken once the previous result sits in the output register.
// Reset (arst_n low) empties the table at once through per-slot valid bits; no clearing pass.
`default_nettype none

module id_table_first_free_insert_core
	import idt_pkg::*;
#(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [2:0]        mode,
	input  wire logic [KEY_W-1:0]  key,
	input  wire logic [KEY_W-1:0]  new_key,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [1:0]             status,
	output logic [SLOT_W-1:0]      slot,
	output logic [KEY_W-1:0]       slot_value,
	output logic                   last
);

	localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	state_t           state_q, state_d;
	mode_t            mode_q;
	logic [KEY_W-1:0] key_q, nkey_q;
	logic [AW-1:0]    idx_q;
	logic [CNT_W-1:0] n_q;
	logic             pend_q;

	status_t           res_status_q, res_status_d;
	logic [SLOT_W-1:0] res_slot_q, res_slot_d;
	logic [KEY_W-1:0]  res_value_q, res_value_d;
	logic              res_last_q, res_last_d;
	logic              res_we;

	logic [KEY_W-1:0]  rd_value;
	logic              rd_en;
	wr_req_t           wr;
	logic              idx_inc, pend_set, n_inc, out_load;

	logic              out_free, idx_last, hit, occupied, rec_last;
	logic [KEY_W-1:0]  target, new_val;
	logic [AW+SLOT_W-1:0] idx_ext;
	logic [SLOT_W-1:0] slot_cur;

	idt_mem #(
		.DEPTH (SLOT_COUNT),
		.AW    (AW)
	) u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.addr     (idx_q),
		.rd_en    (rd_en),
		.wr       (wr),
		.rd_value (rd_value)
	);

	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid || !out_stall;
	assign idx_last = (idx_q == AW'(SLOT_COUNT - 1));
	assign target   = (mode_q == MODE_INSERT) ? '0 : key_q;
	assign hit      = (rd_value == target);
	assign occupied = (rd_value != '0);
	assign rec_last = ((n_q + CNT_W'(1)) == CNT_W'(MAX_RESULTS)) || idx_last;
	assign idx_ext  = {{SLOT_W{1'b0}}, idx_q};
	assign slot_cur = idx_ext[SLOT_W-1:0];

	always_comb begin
		case (mode_q)
			MODE_INSERT: new_val = key_q;
			MODE_UPDATE: new_val = nkey_q;
			MODE_DELETE: new_val = '0;
			default:     new_val = rd_value;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && (mode <= MODE_LIST)) begin
					state_d = S_READ;
				end
			end
			S_READ: state_d = S_CMP;
			S_CMP: begin
				unique case (mode_q)
					MODE_INSERT, MODE_LOOKUP, MODE_UPDATE, MODE_DELETE: begin
						state_d = (hit || idx_last) ? S_EMIT : S_READ;
					end
					MODE_LIST: begin
						if (occupied) begin
							if (pend_q) begin
								state_d = S_LPUSH;
							end else begin
								state_d = rec_last ? S_EMIT : S_READ;
							end
						end else begin
							state_d = idx_last ? S_EMIT : S_READ;
						end
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_LPUSH: begin
				if (out_free) begin
					state_d = rec_last ? S_EMIT : S_READ;
				end
			end
			S_EMIT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		rd_en        = 1'b0;
		wr           = '0;
		idx_inc      = 1'b0;
		pend_set     = 1'b0;
		n_inc        = 1'b0;
		out_load     = 1'b0;
		res_we       = 1'b0;
		res_status_d = res_status_q;
		res_slot_d   = res_slot_q;
		res_value_d  = res_value_q;
		res_last_d   = res_last_q;
		unique case (state_q)
			S_IDLE: ;
			S_READ: rd_en = 1'b1;
			S_CMP: begin
				unique case (mode_q)
					MODE_INSERT, MODE_LOOKUP, MODE_UPDATE, MODE_DELETE: begin
						if (hit) begin
							wr.en        = (mode_q != MODE_LOOKUP);
							wr.data      = new_val;
							res_we       = 1'b1;
							res_status_d = ST_DONE;
							res_slot_d   = slot_cur;
							res_value_d  = new_val;
							res_last_d   = 1'b1;
						end else if (idx_last) begin
							res_we       = 1'b1;
							res_status_d = (mode_q == MODE_INSERT) ? ST_FULL : ST_NOT_FOUND;
							res_slot_d   = '0;
							res_value_d  = '0;
							res_last_d   = 1'b1;
						end else begin
							idx_inc = 1'b1;
						end
					end
					MODE_LIST: begin
						if (occupied) begin
							if (!pend_q) begin
								res_we       = 1'b1;
								res_status_d = ST_DONE;
								res_slot_d   = slot_cur;
								res_value_d  = rd_value;
								res_last_d   = rec_last;
								pend_set     = 1'b1;
								n_inc        = 1'b1;
								idx_inc      = !rec_last;
							end
						end else if (idx_last) begin
							res_we     = 1'b1;
							res_last_d = 1'b1;
							if (!pend_q) begin
								res_status_d = ST_EMPTY;
								res_slot_d   = '0;
								res_value_d  = '0;
							end
						end else begin
							idx_inc = 1'b1;
						end
					end
					default: ;
				endcase
			end
			S_LPUSH: begin
				if (out_free) begin
					out_load     = 1'b1;
					res_we       = 1'b1;
					res_status_d = ST_DONE;
					res_slot_d   = slot_cur;
					res_value_d  = rd_value;
					res_last_d   = rec_last;
					n_inc        = 1'b1;
					idx_inc      = !rec_last;
				end
			end
			S_EMIT: begin
				out_load = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			idx_q     <= '0;
			n_q       <= '0;
			pend_q    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE) begin
				idx_q  <= '0;
				n_q    <= '0;
				pend_q <= 1'b0;
			end else begin
				if (idx_inc) begin
					idx_q <= idx_q + AW'(1);
				end
				if (n_inc) begin
					n_q <= n_q + CNT_W'(1);
				end
				if (pend_set) begin
					pend_q <= 1'b1;
				end
			end
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			mode_q <= mode_t'(mode);
			key_q  <= key;
			nkey_q <= new_key;
		end
		if (res_we) begin
			res_status_q <= res_status_d;
			res_slot_q   <= res_slot_d;
			res_value_q  <= res_value_d;
			res_last_q   <= res_last_d;
		end
		if (out_load) begin
			status     <= res_status_q;
			slot       <= res_slot_q;
			slot_value <= res_value_q;
			last       <= res_last_q;
		end
	end

endmodule

`default_nettype wire

/* hdl/idt_mem.sv */
`default_nettype none

module idt_mem
	import idt_pkg::*;
#(
	parameter int DEPTH = SLOT_COUNT_DEF,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [AW-1:0]    addr,
	input  wire logic             rd_en,
	input  wire wr_req_t          wr,
	output logic      [KEY_W-1:0] rd_value
);

	logic [KEY_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [KEY_W-1:0] rd_data_q;
	logic             rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data_q <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[addr];
			end
		end
	end

	assign rd_value = rd_vld_q ? rd_data_q : '0;

endmodule

`default_nettype wire
